// ===== rtl/core/rf_sample_format_converter_core_defines.svh =====
// assertion macros of the sample format converter, used by its queue module
`ifndef RF_SAMPLE_FORMAT_CONVERTER_CORE_DEFINES_SVH
`define RF_SAMPLE_FORMAT_CONVERTER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// clocked check, masked while reset is asserted
`define RFSC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check that also holds during reset
`define RFSC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RFSC_ASSERT(lbl, clk, rst_n, prop, msg)
`define RFSC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/core/rfsc_pkg.sv =====
// shared types and constants of the sample format converter
package rfsc_pkg;

    // decimation in packed mode with decimation
    localparam int DECIM_FACTOR = 4;
    localparam int SUB_W        = (DECIM_FACTOR > 1) ? $clog2(DECIM_FACTOR) : 1;

    // field widths
    localparam int WORD_W   = 16;
    localparam int SAMPLE_W = 10;
    localparam int BYTE_W   = 8;
    localparam int PACK_BYTES = 5;
    localparam int BIDX_W   = $clog2(PACK_BYTES);

    // front to back queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // configuration register indexes
    localparam logic REG_OUTPUT_FORMAT = 1'b0;
    localparam logic REG_VERIFY_ENABLE = 1'b1;

    // output formats
    localparam logic [1:0] FMT_SCALED16 = 2'd0;

    // kind of work handed to the back end
    typedef enum logic [1:0] {
        ENT_PAIR,
        ENT_PACK,
        ENT_ERR
    } ent_kind_t;

    typedef struct packed {
        ent_kind_t                           kind;
        logic [PACK_BYTES-1:0][BYTE_W-1:0]   bytes;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// ===== rtl/core/rfsc_front.sv =====
// input side: verification, format classification and packing
module rfsc_front import rfsc_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_wr_index,
    input  logic [1:0]           cfg_wr_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [WORD_W-1:0]    s_tdata,
    input  queue_status_t        q_status,
    output logic                 push,
    output entry_t               push_entry
);

    logic [1:0]          format_reg;
    logic                verify_en_reg;
    logic [SAMPLE_W-1:0] expected_reg;
    logic                seeded_reg;
    logic                failed_reg;
    logic [1:0]          slot_reg;
    logic [SUB_W-1:0]    sub_reg;
    logic [SAMPLE_W-1:0] held_reg [3];

    logic                accept;
    logic [SAMPLE_W-1:0] w10;
    logic [SAMPLE_W-1:0] expected_next;
    logic                mismatch;
    logic                keep;
    logic [WORD_W-1:0]   scaled;

    assign s_tready      = !q_status.full;
    assign accept        = s_tvalid && s_tready;
    assign w10           = s_tdata[SAMPLE_W-1:0];
    assign expected_next = expected_reg + 1'b1;
    assign mismatch      = verify_en_reg && seeded_reg &&
                           ({{(WORD_W-SAMPLE_W){1'b0}}, expected_next} != s_tdata);
    assign keep          = (sub_reg == '0);
    assign scaled        = (s_tdata - WORD_W'(512)) << 6;

    // classify the beat into queue work
    always_comb begin
        push             = 1'b0;
        push_entry.kind  = ENT_PAIR;
        push_entry.bytes = '0;
        if (accept && !failed_reg) begin
            if (mismatch) begin
                push            = 1'b1;
                push_entry.kind = ENT_ERR;
            end else if (format_reg == FMT_SCALED16) begin
                push                = 1'b1;
                push_entry.kind     = ENT_PAIR;
                push_entry.bytes[0] = scaled[7:0];
                push_entry.bytes[1] = scaled[15:8];
            end else if (keep && slot_reg == 2'd3) begin
                push                = 1'b1;
                push_entry.kind     = ENT_PACK;
                push_entry.bytes[0] = held_reg[0][9:2];
                push_entry.bytes[1] = {held_reg[0][1:0], held_reg[1][9:4]};
                push_entry.bytes[2] = {held_reg[1][3:0], held_reg[2][9:6]};
                push_entry.bytes[3] = {held_reg[2][5:0], w10[9:8]};
                push_entry.bytes[4] = w10[7:0];
            end
        end
    end

    // configuration, verification and packing phase state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            format_reg    <= FMT_SCALED16;
            verify_en_reg <= 1'b0;
            expected_reg  <= '0;
            seeded_reg    <= 1'b0;
            failed_reg    <= 1'b0;
            slot_reg      <= '0;
            sub_reg       <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    REG_OUTPUT_FORMAT: begin
                        format_reg <= cfg_wr_data;
                        slot_reg   <= '0;
                        sub_reg    <= '0;
                    end
                    REG_VERIFY_ENABLE: verify_en_reg <= cfg_wr_data[0];
                    default: ;
                endcase
            end
            if (accept && !failed_reg) begin
                if (verify_en_reg) begin
                    if (!seeded_reg) begin
                        expected_reg <= w10;
                        seeded_reg   <= 1'b1;
                    end else if (!mismatch) begin
                        expected_reg <= expected_next;
                    end
                end
                if (mismatch) begin
                    failed_reg <= 1'b1;
                end else if (format_reg != FMT_SCALED16) begin
                    if (!format_reg[1]) begin
                        slot_reg <= slot_reg + 1'b1;
                    end else if (sub_reg == SUB_W'(DECIM_FACTOR - 1)) begin
                        sub_reg  <= '0;
                        slot_reg <= slot_reg + 1'b1;
                    end else begin
                        sub_reg <= sub_reg + 1'b1;
                    end
                end
            end
        end
    end

    // held samples of the current packing group
    always_ff @(posedge aclk) begin
        if (accept && !failed_reg && !mismatch && format_reg != FMT_SCALED16 &&
            keep && slot_reg != 2'd3) begin
            held_reg[slot_reg] <= w10;
        end
    end

endmodule

// ===== rtl/core/rfsc_queue.sv =====
// short register queue between front and back
`include "rf_sample_format_converter_core_defines.svh"
module rfsc_queue import rfsc_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  entry_t        push_entry,
    input  logic          pop,
    output entry_t        head,
    output queue_status_t status
);

    entry_t              slots_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic                do_push;
    logic                do_pop;

    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = slots_reg[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: ;
            endcase
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    `RFSC_ASSERT(a_no_overflow, aclk, aresetn, push |-> !status.full, "queue overflow")
    `RFSC_ASSERT(a_no_underflow, aclk, aresetn, pop |-> !status.empty, "queue underflow")
    `RFSC_ASSERT(a_push_counts, aclk, aresetn, (push && !pop) |=> !status.empty,
        "push lost")
    `RFSC_ASSERT(a_count_bound, aclk, aresetn, count_reg <= QCNT_W'(QUEUE_DEPTH),
        "queue count out of range")

endmodule

// ===== rtl/core/rfsc_back.sv =====
// output side: serializes queued work into byte beats
module rfsc_back import rfsc_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  entry_t              head,
    input  queue_status_t       q_status,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [BYTE_W-1:0]   m_tdata,
    output logic                m_tlast,
    output logic                m_tuser
);

    logic [BIDX_W-1:0] bidx_reg;
    logic              valid_reg;
    logic [BYTE_W-1:0] data_reg;
    logic              last_reg;
    logic              err_reg;
    logic              load;
    logic              take;
    logic              last_byte;

    assign load = !valid_reg || m_tready;
    assign take = load && !q_status.empty;
    assign pop  = take && last_byte;

    // final byte of the current entry
    always_comb begin
        case (head.kind)
            ENT_PAIR: last_byte = (bidx_reg == BIDX_W'(1));
            ENT_PACK: last_byte = (bidx_reg == BIDX_W'(PACK_BYTES - 1));
            ENT_ERR:  last_byte = 1'b1;
            default:  last_byte = 1'b1;
        endcase
    end

    // byte index and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bidx_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (load) begin
                valid_reg <= take;
            end
            if (take) begin
                bidx_reg <= last_byte ? '0 : bidx_reg + 1'b1;
            end
        end
    end

    // output payload register
    always_ff @(posedge aclk) begin
        if (take) begin
            data_reg <= head.bytes[bidx_reg];
            last_reg <= last_byte;
            err_reg  <= (head.kind == ENT_ERR);
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = err_reg;

endmodule

// ===== rtl/core/rf_sample_format_converter_core.sv =====
// top level of the sample format converter
// Usage: raw 16-bit capture words enter on the s_ channel, one word per beat;
// output bytes leave on the m_ channel, one byte per beat, with m_tlast on the
// final byte caused by a word and m_tuser on the single verification error beat.
// Format 0 gives two bytes per word (scaled signed 16-bit, low byte first);
// format 1 gives five bytes per four words; formats 2 and 3 keep one word in four
// and give five bytes per sixteen words.
// Configuration is written through cfg_wr_en / cfg_wr_index / cfg_wr_data while
// no beat is in flight; the user must keep to this, the block does not enforce it.
// Index 0 is output_format, index 1 is verify_enable.
// A word is written into the queue at its accepting edge; its bytes then pass
// through the output register to m_tdata. Throughput: the back end emits one
// byte per cycle while m_tready is high, so formats 0 and 1 are bounded by the
// byte output; decimated formats take a word per cycle unless the queue is full.
// A two-entry queue sits between the front (checks, packs) and the back
// (serializes); when the receiver stalls, the queue fills and s_tready drops.
// Reset (aresetn low, synchronous) clears configuration, the test counter,
// the sticky failure and the packing phase; once a mismatch is seen every
// later word is accepted and dropped until reset.
module rf_sample_format_converter_core import rfsc_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_index,
    input  logic [1:0]          cfg_wr_data,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [WORD_W-1:0]   s_tdata,   // [15:0] sample_word
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [BYTE_W-1:0]   m_tdata,   // [7:0] out_byte
    output logic                m_tlast,
    output logic                m_tuser    // [0] verify_error
);

    logic          push;
    logic          pop;
    entry_t        push_entry;
    entry_t        head;
    queue_status_t q_status;

    // front end
    rfsc_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .q_status     (q_status),
        .push         (push),
        .push_entry   (push_entry)
    );

    // decoupling queue
    rfsc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    // back end
    rfsc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== bench/rf_sample_format_converter_core_tb.sv =====
// self-checking bench for the sample format converter: directed table, random phases, stalls
`timescale 1ns / 100ps

module rf_sample_format_converter_core_tb;
    import rfsc_pkg::*;

    // format codes beyond the one the package names
    localparam logic [1:0] FMT_PACKED10    = 2'd1;
    localparam logic [1:0] FMT_DECIM10     = 2'd2;
    localparam logic [1:0] FMT_DECIM10_ALT = 2'd3;

    localparam int IDLE_SETTLE_CYCLES = 16;
    localparam int LONG_HOLD_CYCLES   = 80;
    localparam int END_DRAIN_CYCLES   = 20;

    // one output beat: byte, last byte of the word, verification error flag
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              err;
    } byte_beat_t;

    typedef enum logic [1:0] {
        ROW_WORD,
        ROW_BAD_WORD,
        ROW_SET_FORMAT,
        ROW_SET_VERIFY
    } row_kind_t;

    // n_lit > 0 means the beats are typed in here instead of predicted
    typedef struct packed {
        row_kind_t         kind;
        logic [WORD_W-1:0] val;
        logic [1:0]        n_lit;
        byte_beat_t        lit0;
        byte_beat_t        lit1;
    } row_t;

    localparam byte_beat_t NO_BEAT = '0;
    localparam int NROWS    = 34;
    localparam int FAIL_ROW = 23;

    localparam row_t DIR_ROWS [0:NROWS-1] = '{
        // scaled 16-bit straight after reset: midscale, extremes, one step
        '{ROW_WORD, 16'h0200, 2'd2, '{8'h00, 1'b0, 1'b0}, '{8'h00, 1'b1, 1'b0}},
        '{ROW_WORD, 16'h0000, 2'd2, '{8'h00, 1'b0, 1'b0}, '{8'h80, 1'b1, 1'b0}},
        '{ROW_WORD, 16'hFFFF, 2'd2, '{8'hC0, 1'b0, 1'b0}, '{8'h7F, 1'b1, 1'b0}},
        '{ROW_WORD, 16'h0201, 2'd2, '{8'h40, 1'b0, 1'b0}, '{8'h00, 1'b1, 1'b0}},
        '{ROW_WORD, 16'h5A5A, 2'd0, NO_BEAT, NO_BEAT},
        // packed 10-bit, high bits of the word ignored
        '{ROW_SET_FORMAT, 16'h0001, 2'd0, NO_BEAT, NO_BEAT},
        '{ROW_WORD, 16'h03FF, 2'd0, NO_BEAT, NO_BEAT},
        '{ROW_WORD, 16'h0000, 2'd0, NO_BEAT, NO_BEAT},
        '{ROW_WORD, 16'hFC00, 2'd0, NO_BEAT, NO_BEAT},
        '{ROW_WORD, 16'h03FF, 2'd0, NO_BEAT, NO_BEAT},
        '{ROW_WORD, 16'h8155, 2'd0, NO_BEAT, NO_BEAT},
        '{ROW_WORD, 16'h02AA, 2'd0, NO_BEAT, NO_BEAT},
        '{ROW_WORD, 16'h4133, 2'd0, NO_BEAT, NO_BEAT},
        '{ROW_WORD, 16'h00CC, 2'd0, NO_BEAT, NO_BEAT},
        // test counter: wide seed, wrap, pause with checking off
        '{ROW_SET_FORMAT, 16'h0000, 2'd0, NO_BEAT, NO_BEAT},
        '{ROW_SET_VERIFY, 16'h0003, 2'd0, NO_BEAT, NO_BEAT},
        '{ROW_WORD, 16'h07FE, 2'd0, NO_BEAT, NO_BEAT},
        '{ROW_WORD, 16'h03FF, 2'd0, NO_BEAT, NO_BEAT},
        '{ROW_WORD, 16'h0000, 2'd0, NO_BEAT, NO_BEAT},
        '{ROW_SET_VERIFY, 16'h0000, 2'd0, NO_BEAT, NO_BEAT},
        '{ROW_WORD, 16'hABCD, 2'd0, NO_BEAT, NO_BEAT},
        '{ROW_SET_VERIFY, 16'h0001, 2'd0, NO_BEAT, NO_BEAT},
        '{ROW_WORD, 16'h0001, 2'd0, NO_BEAT, NO_BEAT},
        // mismatch in the high bits, then everything is dropped
        '{ROW_SET_FORMAT, 16'h0000, 2'd0, NO_BEAT, NO_BEAT},
        '{ROW_SET_VERIFY, 16'h0001, 2'd0, NO_BEAT, NO_BEAT},
        '{ROW_BAD_WORD, 16'h0000, 2'd1, '{8'h00, 1'b1, 1'b1}, NO_BEAT},
        '{ROW_WORD, 16'h0001, 2'd0, NO_BEAT, NO_BEAT},
        '{ROW_SET_FORMAT, 16'h0001, 2'd0, NO_BEAT, NO_BEAT},
        '{ROW_WORD, 16'h0000, 2'd0, NO_BEAT, NO_BEAT},
        '{ROW_WORD, 16'h0001, 2'd0, NO_BEAT, NO_BEAT},
        '{ROW_WORD, 16'h0002, 2'd0, NO_BEAT, NO_BEAT},
        '{ROW_WORD, 16'h0003, 2'd0, NO_BEAT, NO_BEAT},
        '{ROW_SET_VERIFY, 16'h0000, 2'd0, NO_BEAT, NO_BEAT},
        '{ROW_WORD, 16'h1234, 2'd0, NO_BEAT, NO_BEAT}
    };

    logic                aclk;
    logic                aresetn      = 1'b0;
    logic                cfg_wr_en    = 1'b0;
    logic                cfg_wr_index = 1'b0;
    logic [1:0]          cfg_wr_data  = 2'd0;
    logic                s_tvalid     = 1'b0;
    logic                s_tready;
    logic [WORD_W-1:0]   s_tdata      = '0;
    logic                m_tvalid;
    logic                m_tready     = 1'b0;
    logic [BYTE_W-1:0]   m_tdata;
    logic                m_tlast;
    logic                m_tuser;

    // predictor state
    logic [1:0]  cur_format;
    logic        cur_verify;
    logic [9:0]  test_count;
    logic        count_seeded;
    logic        stream_failed;
    int unsigned pack_phase;
    logic [9:0]  held [0:2];

    byte_beat_t pending_bytes [$];

    int snd_idle_pct  = 0;
    int rcv_stall_pct = 0;
    bit hold_req      = 1'b0;
    bit hold_ack      = 1'b0;

    int words_sent     = 0;
    int bytes_checked  = 0;
    int mismatch_count = 0;

    rf_sample_format_converter_core uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),    // [15:0] sample_word
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),    // [7:0] out_byte
        .m_tlast      (m_tlast),
        .m_tuser      (m_tuser)     // [0] verify_error
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    // predictor: bytes that one capture word yields, queued in order
    function automatic void emit_group(logic [9:0] w3);
        logic [39:0] bits;
        bits = {held[0], held[1], held[2], w3};
        for (int i = 0; i < 5; i++)
            pending_bytes.push_back('{bits[39-8*i -: 8], i == 4, 1'b0});
    endfunction

    function automatic void convert_word(logic [WORD_W-1:0] w);
        logic [9:0]  nxt;
        logic [15:0] scaled;
        int unsigned period;
        int unsigned ph;
        int unsigned slot;
        if (stream_failed)
            return;
        if (cur_verify) begin
            if (!count_seeded) begin
                test_count   = w[9:0];
                count_seeded = 1'b1;
            end else begin
                nxt = test_count + 10'd1;
                if ({6'b0, nxt} != w) begin
                    stream_failed = 1'b1;
                    pending_bytes.push_back('{8'h00, 1'b1, 1'b1});
                    return;
                end
                test_count = nxt;
            end
        end
        if (cur_format == FMT_SCALED16) begin
            scaled = (w - 16'd512) << 6;
            pending_bytes.push_back('{scaled[7:0], 1'b0, 1'b0});
            pending_bytes.push_back('{scaled[15:8], 1'b1, 1'b0});
            return;
        end
        if (cur_format == FMT_PACKED10) begin
            slot       = pack_phase % 4;
            pack_phase = (slot + 1) % 4;
        end else begin
            // decimated: keep one word per DECIM_FACTOR
            period     = 4 * DECIM_FACTOR;
            ph         = pack_phase % period;
            slot       = ph / DECIM_FACTOR;
            pack_phase = (ph + 1) % period;
            if (ph % DECIM_FACTOR != 0)
                return;
        end
        if (slot < 3)
            held[slot] = w[9:0];
        else
            emit_group(w[9:0]);
    endfunction

    // register write, one beat on the config port
    task automatic write_reg(input logic idx, input logic [1:0] val);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_OUTPUT_FORMAT) begin
            cur_format = val;
            pack_phase = 0;
        end else begin
            cur_verify = val[0];
        end
        @(posedge aclk);
    endtask

    // offer one word, with random idle cycles ahead of it
    task automatic push_word(input logic [WORD_W-1:0] w);
        bit rdy;
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        do begin
            @(negedge aclk);
            rdy = s_tready;
            @(posedge aclk);
        end while (!rdy);
        words_sent++;
    endtask

    // drain all expected bytes, then let unreported words settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge aclk);
        repeat (IDLE_SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apply_rows(input int first, input int stop);
        row_t             rw;
        logic [WORD_W-1:0] w;
        int               n_before;
        for (int r = first; r < stop; r++) begin
            rw = DIR_ROWS[r];
            case (rw.kind)
                ROW_SET_FORMAT: begin
                    wait_idle();
                    write_reg(REG_OUTPUT_FORMAT, rw.val[1:0]);
                end
                ROW_SET_VERIFY: begin
                    wait_idle();
                    write_reg(REG_VERIFY_ENABLE, rw.val[1:0]);
                end
                default: begin
                    // a bad word breaks the counter sequence in its high bits
                    if (rw.kind == ROW_BAD_WORD)
                        w = {6'b000001, test_count + 10'd1};
                    else
                        w = rw.val;
                    push_word(w);
                    n_before = pending_bytes.size();
                    convert_word(w);
                    if (rw.n_lit != 0) begin
                        while (pending_bytes.size() > n_before)
                            void'(pending_bytes.pop_back());
                        pending_bytes.push_back(rw.lit0);
                        if (rw.n_lit > 1)
                            pending_bytes.push_back(rw.lit1);
                    end
                end
            endcase
        end
    endtask

    // counter sequence while checking, otherwise random with some extremes
    function automatic logic [WORD_W-1:0] pick_word();
        if (cur_verify && count_seeded)
            return {6'b0, test_count + 10'd1};
        case ($urandom_range(0, 11))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h03FF;
            3:       return 16'h0200;
            default: return WORD_W'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    task automatic run_phase(input logic [1:0] fmt, input logic [1:0] ver, input int n_words,
                             input int snd_pct, input int rcv_pct, input bit long_hold);
        logic [WORD_W-1:0] w;
        wait_idle();
        snd_idle_pct  = snd_pct;
        rcv_stall_pct = rcv_pct;
        write_reg(REG_OUTPUT_FORMAT, fmt);
        write_reg(REG_VERIFY_ENABLE, ver);
        if (long_hold)
            hold_req = ~hold_req;
        for (int i = 0; i < n_words; i++) begin
            w = pick_word();
            push_word(w);
            convert_word(w);
        end
    endtask

    // receiver: random stalls, or one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req != hold_ack) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge aclk);
                hold_ack = hold_req;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= rcv_stall_pct);
            end
        end
    end

    // compare every accepted output beat with the oldest expectation
    always @(posedge aclk) begin
        byte_beat_t exp_beat;
        if (aresetn && m_tvalid && m_tready) begin
            bytes_checked++;
            if (pending_bytes.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual byte %h last %b err %b",
                         $time, m_tdata, m_tlast, m_tuser);
                mismatch_count++;
            end else begin
                exp_beat = pending_bytes.pop_front();
                if (m_tdata !== exp_beat.data) begin
                    $display("%0t: out_byte expected %h actual %h",
                             $time, exp_beat.data, m_tdata);
                    mismatch_count++;
                end
                if (m_tlast !== exp_beat.last) begin
                    $display("%0t: last_in_run expected %b actual %b",
                             $time, exp_beat.last, m_tlast);
                    mismatch_count++;
                end
                if (m_tuser !== exp_beat.err) begin
                    $display("%0t: verify_error expected %b actual %b",
                             $time, exp_beat.err, m_tuser);
                    mismatch_count++;
                end
            end
        end
    end

    // main sequence
    initial begin
        cur_format    = FMT_SCALED16;
        cur_verify    = 1'b0;
        test_count    = '0;
        count_seeded  = 1'b0;
        stream_failed = 1'b0;
        pack_phase    = 0;
        held[0]       = '0;
        held[1]       = '0;
        held[2]       = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        apply_rows(0, FAIL_ROW);

        run_phase(FMT_DECIM10,     2'd1, 30,  0,  0, 1'b0);
        run_phase(FMT_DECIM10_ALT, 2'd0, 30, 56,  0, 1'b0);
        run_phase(FMT_PACKED10,    2'd1, 28,  0, 56, 1'b0);
        run_phase(FMT_SCALED16,    2'd0, 28, 33, 33, 1'b0);
        // receiver holds off while words keep coming, input must back up
        run_phase(FMT_SCALED16,    2'd1, 14,  0,  0, 1'b1);

        apply_rows(FAIL_ROW, NROWS);
        wait_idle();
        repeat (END_DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d words across all format codes, counter checks and a forced mismatch;",
                 words_sent);
        $display("checked %0d output bytes under idle, stall and long hold-off conditions",
                 bytes_checked);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/rfsc_pkg.sv
rtl/core/rfsc_front.sv
rtl/core/rfsc_queue.sv
rtl/core/rfsc_back.sv
rtl/core/rf_sample_format_converter_core.sv
bench/rf_sample_format_converter_core_tb.sv
